### hdl/undo_history_ring_manager_macros.svh
// ----------------------------------------------------------------------------
// Undo history ring manager assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef UNDO_HISTORY_RING_MANAGER_MACROS_SVH
`define UNDO_HISTORY_RING_MANAGER_MACROS_SVH

// Same-cycle implication
`define UHR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define UHR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/uhr_pkg.sv
// ----------------------------------------------------------------------------
// uhr_pkg
// Shared types and constants of the undo history ring manager.
// ----------------------------------------------------------------------------
`default_nettype none

package uhr_pkg;

  // Ring geometry
  localparam int DEPTH     = 64;
  localparam int SLOT_W    = 6;
  localparam int CNT_W     = 7;
  localparam int MIN_KEEP  = 3;

  // Field widths
  localparam int SIZE_W    = 40;
  localparam int TOTAL_W   = 46;
  localparam int BUDGET_W  = 20;
  localparam int MIB_SHIFT = 20;
  localparam int MAXE_W    = 7;

  // Register port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register index, taken from the word address bit
  localparam logic REG_MAX_ENTRIES = 1'b0;
  localparam logic REG_BUDGET_MB   = 1'b1;

  localparam logic [MAXE_W-1:0]   MAX_ENTRIES_RST = 7'd64;
  localparam logic [BUDGET_W-1:0] BUDGET_MB_RST   = 20'd512;

  typedef enum logic [2:0] {
    OP_SAVE      = 3'd0,
    OP_TRUNC     = 3'd1,
    OP_SAVE_INIT = 3'd2,
    OP_UNDO      = 3'd3,
    OP_REDO      = 3'd4,
    OP_CLEAR     = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_STORE   = 2'd1,
    ACT_RESTORE = 2'd2
  } slot_action_t;

endpackage

`default_nettype wire

### hdl/uhr_in_if.sv
// ----------------------------------------------------------------------------
// uhr_in_if
// Operation channel: valid/ready handshake with the operation payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface uhr_in_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    opcode;
  logic                          has_image;
  logic [uhr_pkg::SIZE_W-1:0]    snapshot_bytes;

  modport source (output valid, output opcode, output has_image, output snapshot_bytes,
                  input ready);
  modport sink   (input valid, input opcode, input has_image, input snapshot_bytes,
                  output ready);
endinterface

`default_nettype wire

### hdl/uhr_out_if.sv
// ----------------------------------------------------------------------------
// uhr_out_if
// Result channel: valid/ready handshake with slot and history status.
// ----------------------------------------------------------------------------
`default_nettype none

interface uhr_out_if;
  logic                          valid;
  logic                          ready;
  logic                          done_res;
  logic [1:0]                    slot_action;
  logic [uhr_pkg::SLOT_W-1:0]    slot;
  logic [uhr_pkg::CNT_W-1:0]     entry_count;
  logic [uhr_pkg::SLOT_W-1:0]    position;
  logic                          can_undo;
  logic                          can_redo;
  logic [uhr_pkg::TOTAL_W-1:0]   bytes_in_use;
  logic [uhr_pkg::CNT_W-1:0]     evicted;

  modport source (output valid, output done_res, output slot_action, output slot,
                  output entry_count, output position, output can_undo, output can_redo,
                  output bytes_in_use, output evicted, input ready);
  modport sink   (input valid, input done_res, input slot_action, input slot,
                  input entry_count, input position, input can_undo, input can_redo,
                  input bytes_in_use, input evicted, output ready);
endinterface

`default_nettype wire

### hdl/undo_history_ring_manager.sv
// ----------------------------------------------------------------------------
// undo_history_ring_manager
// Snapshot history bookkeeping: ring of snapshot sizes with a cursor.
// ----------------------------------------------------------------------------
// One operation is taken at a time; ready is high only while the sequencer is
// idle. Undo, redo, save initial, clear and refused operations pass from
// S_IDLE through S_FIN to the output register. Save and truncate walk the ring
// through a single registered read port and one shared 46-bit add/subtract
// unit, dropping redo entries via S_REDO and S_REDO_SUB; a save then evicts
// and stores via S_TRIM, S_TRIM_SUB and S_STORE. A finished result sits in an
// output register, so the next operation can be taken while it waits. No
// clearing pass after reset: ring entries are only read inside the live count.
`default_nettype none

module undo_history_ring_manager (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // register port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [uhr_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [uhr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [uhr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  // channels
  uhr_in_if.sink                                 in_ch,
  uhr_out_if.source                              out_ch
);

  localparam int SW = uhr_pkg::SLOT_W;
  localparam int CW = uhr_pkg::CNT_W;
  localparam int TW = uhr_pkg::TOTAL_W;
  localparam int ZW = uhr_pkg::SIZE_W;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_REDO     = 7'b0000010,
    S_REDO_SUB = 7'b0000100,
    S_TRIM     = 7'b0001000,
    S_TRIM_SUB = 7'b0010000,
    S_STORE    = 7'b0100000,
    S_FIN      = 7'b1000000
  } state_t;

  state_t                          state;
  logic [uhr_pkg::MAXE_W-1:0]      max_entries;
  logic [uhr_pkg::BUDGET_W-1:0]    budget_mb;

  logic [SW-1:0]                   oldest;
  logic [CW-1:0]                   count;
  logic [SW-1:0]                   cursor;
  logic [TW-1:0]                   total;

  logic [ZW-1:0]                   size_q;
  logic                            save_op;
  logic                            post_phase;
  logic                            done_q;
  uhr_pkg::slot_action_t           action_q;
  logic [SW-1:0]                   slot_q;
  logic [CW-1:0]                   evicted;

  logic [ZW-1:0]                   mem [uhr_pkg::DEPTH];
  logic [ZW-1:0]                   rdata;
  logic [SW-1:0]                   raddr;
  logic                            mem_we;
  logic [SW-1:0]                   waddr;
  logic [ZW-1:0]                   wdata;

  logic                            out_valid;
  logic                            in_acc;
  logic                            has_redo;
  logic                            over_budget;
  logic                            need_drop;
  logic [CW-1:0]                   lim;
  logic [TW-1:0]                   addend;
  logic [TW-1:0]                   total_next;

  // --------------------------------------------------------------------------
  // Register port; byte lane bits of paddr are ignored
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= uhr_pkg::MAX_ENTRIES_RST;
      budget_mb   <= uhr_pkg::BUDGET_MB_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == uhr_pkg::REG_BUDGET_MB) begin
        budget_mb <= pwdata[uhr_pkg::BUDGET_W-1:0];
      end else begin
        max_entries <= pwdata[uhr_pkg::MAXE_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == uhr_pkg::REG_BUDGET_MB) begin
      prdata = {{(uhr_pkg::APB_DATA_W-uhr_pkg::BUDGET_W){1'b0}}, budget_mb};
    end else begin
      prdata = {{(uhr_pkg::APB_DATA_W-uhr_pkg::MAXE_W){1'b0}}, max_entries};
    end
  end

  // --------------------------------------------------------------------------
  // Conditions
  // --------------------------------------------------------------------------
  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && (state == S_IDLE);
  assign has_redo    = ({1'b0, cursor} + CW'(1)) < count;

  // count limit: zero acts as one, above ring depth acts as depth
  always_comb begin
    if (max_entries == '0) begin
      lim = CW'(1);
    end else if (max_entries > CW'(uhr_pkg::DEPTH)) begin
      lim = CW'(uhr_pkg::DEPTH);
    end else begin
      lim = max_entries;
    end
  end

  assign over_budget = total > {{(TW-uhr_pkg::BUDGET_W-uhr_pkg::MIB_SHIFT){1'b0}},
                                budget_mb, {uhr_pkg::MIB_SHIFT{1'b0}}};

  // before the store only a full ring drops; after it, count then budget
  assign need_drop = post_phase ?
                     ((count > lim) || (over_budget && (count > CW'(uhr_pkg::MIN_KEEP)))) :
                     (count >= CW'(uhr_pkg::DEPTH));

  // shared add/subtract unit on the byte total
  assign addend     = (state == S_STORE) ? {{(TW-ZW){1'b0}}, size_q}
                                         : {{(TW-ZW){1'b0}}, rdata};
  assign total_next = (state == S_STORE) ? total + addend : total - addend;

  // --------------------------------------------------------------------------
  // Size ring: one write port, one registered read port
  // --------------------------------------------------------------------------
  assign raddr = (state == S_REDO) ? SW'(oldest + count[SW-1:0] - SW'(1)) : oldest;

  always_comb begin
    if (state == S_STORE) begin
      mem_we = 1'b1;
      waddr  = SW'(oldest + count[SW-1:0]);
      wdata  = size_q;
    end else begin
      mem_we = in_acc && in_ch.has_image &&
               (uhr_pkg::opcode_t'(in_ch.opcode) == uhr_pkg::OP_SAVE_INIT);
      waddr  = '0;
      wdata  = in_ch.snapshot_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      oldest     <= '0;
      count      <= '0;
      cursor     <= '0;
      total      <= '0;
      out_valid  <= 1'b0;
      post_phase <= 1'b0;
      save_op    <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            size_q     <= in_ch.snapshot_bytes;
            evicted    <= '0;
            done_q     <= 1'b0;
            action_q   <= uhr_pkg::ACT_NONE;
            slot_q     <= '0;
            post_phase <= 1'b0;
            save_op    <= (uhr_pkg::opcode_t'(in_ch.opcode) == uhr_pkg::OP_SAVE);
            state      <= S_FIN;
            unique case (uhr_pkg::opcode_t'(in_ch.opcode))
              uhr_pkg::OP_SAVE, uhr_pkg::OP_TRUNC: begin
                if (in_ch.has_image) begin
                  done_q <= 1'b1;
                  state  <= S_REDO;
                  if (uhr_pkg::opcode_t'(in_ch.opcode) == uhr_pkg::OP_SAVE) begin
                    action_q <= uhr_pkg::ACT_STORE;
                  end
                end
              end
              uhr_pkg::OP_SAVE_INIT: begin
                if (in_ch.has_image) begin
                  oldest   <= '0;
                  total    <= {{(TW-ZW){1'b0}}, in_ch.snapshot_bytes};
                  count    <= CW'(1);
                  cursor   <= '0;
                  done_q   <= 1'b1;
                  action_q <= uhr_pkg::ACT_STORE;
                end
              end
              uhr_pkg::OP_UNDO: begin
                if (count != '0 && cursor != '0) begin
                  cursor   <= cursor - SW'(1);
                  slot_q   <= SW'(oldest + cursor - SW'(1));
                  done_q   <= 1'b1;
                  action_q <= uhr_pkg::ACT_RESTORE;
                end
              end
              uhr_pkg::OP_REDO: begin
                if (has_redo) begin
                  cursor   <= cursor + SW'(1);
                  slot_q   <= SW'(oldest + cursor + SW'(1));
                  done_q   <= 1'b1;
                  action_q <= uhr_pkg::ACT_RESTORE;
                end
              end
              uhr_pkg::OP_CLEAR: begin
                oldest <= '0;
                count  <= '0;
                cursor <= '0;
                total  <= '0;
                done_q <= 1'b1;
              end
              default: begin
                // unknown opcode: refused, status only
              end
            endcase
          end
        end

        // drop newest entries beyond the cursor; read issued here
        S_REDO: begin
          if (has_redo) begin
            state <= S_REDO_SUB;
          end else if (save_op) begin
            state <= S_TRIM;
          end else begin
            state <= S_FIN;
          end
        end

        S_REDO_SUB: begin
          total <= total_next;
          count <= count - CW'(1);
          state <= S_REDO;
        end

        // evict oldest entries; read of the oldest slot issued here
        S_TRIM: begin
          if (need_drop) begin
            state <= S_TRIM_SUB;
          end else if (!post_phase) begin
            state <= S_STORE;
          end else begin
            state <= S_FIN;
          end
        end

        S_TRIM_SUB: begin
          total   <= total_next;
          oldest  <= oldest + SW'(1);
          count   <= count - CW'(1);
          evicted <= evicted + CW'(1);
          if (cursor != '0) begin
            cursor <= cursor - SW'(1);
          end
          state <= S_TRIM;
        end

        // append the new entry and move the cursor onto it
        S_STORE: begin
          total      <= total_next;
          slot_q     <= SW'(oldest + count[SW-1:0]);
          cursor     <= count[SW-1:0];
          count      <= count + CW'(1);
          post_phase <= 1'b1;
          state      <= S_TRIM;
        end

        // hand the result to the output register once it is free
        S_FIN: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic                  r_done;
  logic [1:0]            r_action;
  logic [SW-1:0]         r_slot;
  logic [CW-1:0]         r_count;
  logic [SW-1:0]         r_position;
  logic                  r_can_undo;
  logic                  r_can_redo;
  logic [TW-1:0]         r_bytes;
  logic [CW-1:0]         r_evicted;

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_valid || out_ch.ready)) begin
      r_done     <= done_q;
      r_action   <= action_q;
      r_slot     <= slot_q;
      r_count    <= count;
      r_position <= (count == '0) ? '0 : cursor;
      r_can_undo <= (count != '0) && (cursor != '0);
      r_can_redo <= has_redo;
      r_bytes    <= total;
      r_evicted  <= evicted;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.done_res     = r_done;
  assign out_ch.slot_action  = r_action;
  assign out_ch.slot         = r_slot;
  assign out_ch.entry_count  = r_count;
  assign out_ch.position     = r_position;
  assign out_ch.can_undo     = r_can_undo;
  assign out_ch.can_redo     = r_can_redo;
  assign out_ch.bytes_in_use = r_bytes;
  assign out_ch.evicted      = r_evicted;

endmodule

`default_nettype wire

### hdl/uhr_checker.sv
// ----------------------------------------------------------------------------
// uhr_checker
// Port-level assertions for the undo history ring manager, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "undo_history_ring_manager_macros.svh"

module uhr_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          done_res,
  input wire logic [1:0]                    slot_action,
  input wire logic [uhr_pkg::CNT_W-1:0]     entry_count,
  input wire logic [uhr_pkg::SLOT_W-1:0]    position,
  input wire logic                          can_undo,
  input wire logic                          can_redo,
  input wire logic [uhr_pkg::CNT_W-1:0]     evicted
);

  // result held until taken
  `UHR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // one operation at a time: busy right after a transfer
  `UHR_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready, "ready after transfer")

  // refused operations name no slot; only saves evict
  `UHR_ASSERT_NOW(a_action_consistent, out_valid,
    (done_res || slot_action == uhr_pkg::ACT_NONE) &&
    (evicted == '0 || slot_action == uhr_pkg::ACT_STORE), "inconsistent slot action")

  // cursor inside the history and flags agree with it
  `UHR_ASSERT_NOW(a_cursor_range, out_valid,
    (entry_count <= uhr_pkg::CNT_W'(uhr_pkg::DEPTH)) &&
    (entry_count != '0 || (position == '0 && !can_redo)) &&
    (entry_count == '0 || {1'b0, position} < entry_count) &&
    (can_undo == (position != '0)), "cursor status out of range")

endmodule

bind undo_history_ring_manager uhr_checker u_uhr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .done_res    (out_ch.done_res),
  .slot_action (out_ch.slot_action),
  .entry_count (out_ch.entry_count),
  .position    (out_ch.position),
  .can_undo    (out_ch.can_undo),
  .can_redo    (out_ch.can_redo),
  .evicted     (out_ch.evicted)
);

`default_nettype wire
